FILE: rtl/tfn_pkg.sv
// package for the triangle face normal block: widths and shared types
// no dependencies
`default_nettype none
package tfn_pkg;
   localparam int COORD_BITS_DEF       = 16;
   localparam int NORMAL_FRAC_BITS_DEF = 14;
   localparam int OUT_BITS             = 16;
   localparam int RED_BITS             = 31;   // reduced magnitude width
   localparam int ROOT_BITS            = RED_BITS + 1;   // root of a sum of three squares
   localparam int SUM_BITS             = 64;

   typedef enum logic [1:0] {
      OP_SQRT = 2'd0,
      OP_DIV  = 2'd1
   } tfn_op_type;

   typedef struct packed {
      logic       start;
      tfn_op_type op;
   } tfn_cmd_type;
endpackage
`default_nettype wire

FILE: rtl/tfn_unit.sv
// shared iterative unit: integer square root or restoring divide, one bit a cycle
// depends on tfn_pkg
`default_nettype none
module tfn_unit
   import tfn_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire tfn_cmd_type               cmd,
   input  wire logic [SUM_BITS-1:0]       opa,     // radicand or dividend
   input  wire logic [ROOT_BITS-1:0]      opb,     // divisor
   output logic                           done,
   output logic [SUM_BITS-1:0]            result
);
   localparam int CW = 7;

   logic [SUM_BITS-1:0] rem_ff, rem_in, acc_ff, acc_in, num_ff, num_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                busy_ff, busy_in, done_ff, done_in;
   tfn_op_type          op_ff, op_in;
   logic [SUM_BITS+1:0] trial;
   logic [SUM_BITS+1:0] shrem;

   always_comb begin
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      num_in  = num_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      trial   = '0;
      shrem   = '0;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         rem_in  = '0;
         acc_in  = '0;
         num_in  = opa;
         cnt_in  = (cmd.op == OP_SQRT) ? CW'(SUM_BITS/2) : CW'(SUM_BITS);
      end else if (busy_ff) begin
         if (op_ff == OP_SQRT) begin
            // bring down two radicand bits, trial subtract 4r+1
            shrem = {rem_ff, num_ff[SUM_BITS-1 -: 2]};
            trial = shrem - {acc_ff, 2'b01};
            num_in = {num_ff[SUM_BITS-3:0], 2'b00};
            if (!trial[SUM_BITS+1]) begin
               rem_in = trial[SUM_BITS-1:0];
               acc_in = {acc_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = shrem[SUM_BITS-1:0];
               acc_in = {acc_ff[SUM_BITS-2:0], 1'b0};
            end
         end else begin
            shrem = {1'b0, rem_ff, num_ff[SUM_BITS-1]};
            trial = shrem - (SUM_BITS+2)'(opb);
            num_in = {num_ff[SUM_BITS-2:0], 1'b0};
            if (!trial[SUM_BITS+1]) begin
               rem_in = trial[SUM_BITS-1:0];
               acc_in = {acc_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = shrem[SUM_BITS-1:0];
               acc_in = {acc_ff[SUM_BITS-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_SQRT;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      num_ff <= num_in;
   end

   assign done   = done_ff;
   assign result = acc_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("done without busy");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff) else $error("start while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("busy after done");
`endif
endmodule
`default_nettype wire

FILE: rtl/triangle_face_normal_top.sv
// top level of the triangle face normal block: vertex grouping and sequencer
// depends on tfn_pkg and tfn_unit
// sequence: the first two corners are only held; a third corner starts the computation:
//   edges, products, reduction (one shift per step while a magnitude is too wide), squares,
//   root, then three divides on the shared unit
// degenerate triangle: no divides, results are zero
// input: not ready while a triangle is computed or its three result transfers are pending
// reset: synchronous active high, clears held corners, phase and output valid
`default_nettype none
module triangle_face_normal_top
   import tfn_pkg::*;
#(
   parameter int COORD_BITS       = COORD_BITS_DEF,
   parameter int NORMAL_FRAC_BITS = NORMAL_FRAC_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   // coord_x, coord_y, coord_z from bit 0 up, zero padded to bytes
   input  wire logic [((3*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  wire logic                    req_tuser,  // new_mesh
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [47:0]                  rsp_tdata,  // normal_x, normal_y, normal_z
   output logic                         rsp_tuser,  // degenerate
   output logic                         rsp_tlast   // last_copy
);
   localparam int CB = COORD_BITS;
   localparam int PW = 64;

   typedef enum logic [3:0] {
      S_IDLE, S_EDGE, S_MUL, S_RED, S_SQ, S_SQRT_GO, S_SQRT_WAIT,
      S_DIV_GO, S_DIV_WAIT, S_OUT
   } state_type;

   state_type              state_ff;
   logic [1:0]             phase_ff;
   logic signed [CB-1:0]   v1_ff [3], v2_ff [3], v3_ff [3];
   logic signed [CB:0]     e1_ff [3], e2_ff [3];
   logic signed [PW-1:0]   cr_ff [3];
   logic [PW-1:0]          mag_ff [3];
   logic                   neg_ff [3];
   logic [PW-1:0]          sum_ff;
   logic [ROOT_BITS-1:0]   m_ff;
   logic [OUT_BITS-1:0]    res_ff [3];
   logic                   deg_ff;
   logic [2:0]             step_ff;
   logic [1:0]             k_ff;
   logic [1:0]             copy_ff;
   logic                   ovalid_ff;
   logic signed [2*CB+1:0] prod_w;
   logic signed [PW-1:0]   prod;
   logic [RED_BITS-1:0]    mk;
   logic [2*RED_BITS-1:0]  sq_half;
   logic [PW-1:0]          sq;
   logic [PW-1:0]          q;
   tfn_cmd_type            cmd;
   logic [PW-1:0]          opa;
   logic                   udone;
   logic [PW-1:0]          ures;
   logic signed [CB-1:0]   vin [3];

   assign vin[0] = req_tdata[CB-1:0];
   assign vin[1] = req_tdata[2*CB-1:CB];
   assign vin[2] = req_tdata[3*CB-1:2*CB];

   // shared multiplier: one partial cross-product term a cycle, edge-wide operands
   always_comb begin
      case (step_ff)
         3'd0: prod_w = e1_ff[1] * e2_ff[2];
         3'd1: prod_w = e1_ff[2] * e2_ff[1];
         3'd2: prod_w = e1_ff[2] * e2_ff[0];
         3'd3: prod_w = e1_ff[0] * e2_ff[2];
         3'd4: prod_w = e1_ff[0] * e2_ff[1];
         default: prod_w = e1_ff[1] * e2_ff[0];
      endcase
   end
   assign prod = PW'(prod_w);

   // squares of reduced magnitudes; each magnitude fits below 2^31
   assign mk      = mag_ff[k_ff][RED_BITS-1:0];
   assign sq_half = mk * mk;
   assign sq      = PW'(sq_half);
   assign opa = (state_ff == S_SQRT_GO) ? sum_ff
              : (mag_ff[k_ff] << NORMAL_FRAC_BITS) + PW'(m_ff >> 1);
   always_comb begin
      cmd.start = (state_ff == S_SQRT_GO) || ((state_ff == S_DIV_GO) && (m_ff != '0));
      cmd.op    = (state_ff == S_SQRT_GO) ? OP_SQRT : OP_DIV;
   end
   assign q = neg_ff[k_ff] ? (PW'(0) - ures) : ures;

   tfn_unit u_unit (
      .clock(clock), .reset(reset), .cmd(cmd), .opa(opa), .opb(m_ff),
      .done(udone), .result(ures)
   );

   assign req_tready = (state_ff == S_IDLE);
   wire req_xfer = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= '0;
         ovalid_ff <= 1'b0;
         step_ff   <= '0;
         k_ff      <= '0;
         copy_ff   <= '0;
         for (int i = 0; i < 3; i++) begin
            v1_ff[i] <= '0;
            v2_ff[i] <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_xfer) begin
                  if (req_tuser || phase_ff == 2'd0 || phase_ff == 2'd3) begin
                     for (int i = 0; i < 3; i++) v1_ff[i] <= vin[i];
                     phase_ff <= 2'd1;
                  end else if (phase_ff == 2'd1) begin
                     for (int i = 0; i < 3; i++) v2_ff[i] <= vin[i];
                     phase_ff <= 2'd2;
                  end else begin
                     for (int i = 0; i < 3; i++) v3_ff[i] <= vin[i];
                     phase_ff <= 2'd0;
                     state_ff <= S_EDGE;
                  end
               end
            end
            S_EDGE: begin
               for (int i = 0; i < 3; i++) begin
                  e1_ff[i] <= (CB+1)'(v1_ff[i]) - (CB+1)'(v2_ff[i]);
                  e2_ff[i] <= (CB+1)'(v3_ff[i]) - (CB+1)'(v1_ff[i]);
               end
               step_ff  <= '0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               // even steps load, odd steps subtract
               if (!step_ff[0]) cr_ff[step_ff[2:1]] <= prod;
               else cr_ff[step_ff[2:1]] <= cr_ff[step_ff[2:1]] - prod;
               if (step_ff == 3'd5) begin
                  step_ff  <= '0;
                  state_ff <= S_RED;
               end else begin
                  step_ff <= step_ff + 3'd1;
               end
            end
            S_RED: begin
               // magnitudes, signs, degenerate flag, shift one bit a cycle
               if (step_ff == 3'd0) begin
                  for (int i = 0; i < 3; i++) begin
                     neg_ff[i] <= cr_ff[i][PW-1];
                     mag_ff[i] <= cr_ff[i][PW-1] ? PW'(0) - cr_ff[i] : cr_ff[i];
                  end
                  deg_ff  <= (cr_ff[0] == '0) && (cr_ff[1] == '0) && (cr_ff[2] == '0);
                  step_ff <= 3'd1;
               end else if ((mag_ff[0] >> RED_BITS) != '0 || (mag_ff[1] >> RED_BITS) != '0
                            || (mag_ff[2] >> RED_BITS) != '0) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else begin
                  sum_ff   <= '0;
                  k_ff     <= '0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               sum_ff <= sum_ff + sq;
               k_ff   <= k_ff + 2'd1;
               if (k_ff == 2'd2) state_ff <= S_SQRT_GO;
            end
            S_SQRT_GO: state_ff <= S_SQRT_WAIT;
            S_SQRT_WAIT: begin
               if (udone) begin
                  m_ff <= ures[ROOT_BITS-1:0];
                  k_ff <= '0;
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               if (m_ff == '0) begin
                  for (int i = 0; i < 3; i++) res_ff[i] <= '0;
                  copy_ff   <= '0;
                  ovalid_ff <= 1'b1;
                  state_ff  <= S_OUT;
               end else begin
                  state_ff <= S_DIV_WAIT;
               end
            end
            S_DIV_WAIT: begin
               if (udone) begin
                  res_ff[k_ff] <= q[OUT_BITS-1:0];
                  k_ff <= k_ff + 2'd1;
                  if (k_ff == 2'd2) begin
                     copy_ff   <= '0;
                     ovalid_ff <= 1'b1;
                     state_ff  <= S_OUT;
                  end else begin
                     state_ff <= S_DIV_GO;
                  end
               end
            end
            S_OUT: begin
               if (rsp_tready) begin
                  copy_ff <= copy_ff + 2'd1;
                  if (copy_ff == 2'd2) begin
                     ovalid_ff <= 1'b0;
                     state_ff  <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {res_ff[2], res_ff[1], res_ff[0]};
   assign rsp_tuser  = deg_ff;
   assign rsp_tlast  = (copy_ff == 2'd2);

`ifndef SYNTHESIS
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == S_OUT) else $error("result valid outside output");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting while results pending");
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> rsp_tdata == '0) else $error("degenerate not zero");
`endif
endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// testbench for triangle_face_normal_top: directed table then random vertex stream
// depends on tfn_pkg and the rtl of triangle_face_normal_top
`timescale 1ns / 1ps
module testbench;
   import tfn_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int FB = NORMAL_FRAC_BITS_DEF;
   localparam int TDW = ((3*CB+7)/8)*8;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS = 190;

   typedef struct packed {
      logic [15:0] nx;
      logic [15:0] ny;
      logic [15:0] nz;
      logic        degen;
      logic        last;
   } normal_type;

   // directed vertex with optional typed-in normal for the third corner
   typedef struct {
      logic [15:0] x, y, z;
      logic        mesh;
      logic        known;
      normal_type  want;
   } vertex_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [TDW-1:0] req_tdata = '0;     // coord_x, coord_y, coord_z
   logic req_tuser = 1'b0;             // new_mesh
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;             // normal_x, normal_y, normal_z
   logic rsp_tuser;                    // degenerate
   logic rsp_tlast;                    // last_copy

   // predictor state
   logic signed [63:0] corner_a [3];
   logic signed [63:0] corner_b [3];
   logic [1:0] phase;

   normal_type pending_normals [$];
   normal_type typed_normals [$];   // typed-in values, checked alongside the predictor
   logic typed_flags [$];
   int failures = 0;
   int idle_cycles = 0;
   int stall_left = 0;

   triangle_face_normal_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic logic [63:0] root_floor(logic [63:0] s);
      logic [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // advance predictor by one vertex; returns 1 and the normal when a triangle completes
   function automatic logic face_normal(input logic [15:0] x, y, z, input logic mesh,
                                        output normal_type n);
      logic signed [63:0] v [3];
      logic signed [63:0] e1 [3], e2 [3], c [3];
      logic [63:0] mag [3], big, sum, m, q;
      logic [15:0] res [3];
      int sh;
      v[0] = $signed(x); v[1] = $signed(y); v[2] = $signed(z);
      n = '0;
      if (mesh || phase == 2'd0 || phase == 2'd3) begin
         corner_a = v;
         phase = 2'd1;
         return 1'b0;
      end
      if (phase == 2'd1) begin
         corner_b = v;
         phase = 2'd2;
         return 1'b0;
      end
      for (int k = 0; k < 3; k++) begin
         e1[k] = corner_a[k] - corner_b[k];
         e2[k] = v[k] - corner_a[k];
      end
      c[0] = e1[1]*e2[2] - e1[2]*e2[1];
      c[1] = e1[2]*e2[0] - e1[0]*e2[2];
      c[2] = e1[0]*e2[1] - e1[1]*e2[0];
      big = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = c[k] < 0 ? -c[k] : c[k];
         if (mag[k] > big) big = mag[k];
      end
      sh = 0;
      while ((big >> sh) >= (64'd1 << 31)) sh++;
      for (int k = 0; k < 3; k++) mag[k] = mag[k] >> sh;
      sum = mag[0]*mag[0] + mag[1]*mag[1] + mag[2]*mag[2];
      m = root_floor(sum);
      for (int k = 0; k < 3; k++) begin
         q = 0;
         if (m != 0) q = ((mag[k] << FB) + (m >> 1)) / m;
         if (c[k] < 0) q = -q;
         res[k] = q[15:0];
      end
      n.nx = res[0]; n.ny = res[1]; n.nz = res[2];
      n.degen = (big == 0);
      phase = 2'd0;
      return 1'b1;
   endfunction

   task automatic send_vertex(input logic [15:0] x, y, z, input logic mesh,
                              input logic known, input normal_type want);
      normal_type n;
      int gap;
      gap = 0;
      if ($urandom_range(3) == 0)
         gap = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(TDW-48){1'b0}}, z, y, x};
      req_tuser <= mesh;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (face_normal(x, y, z, mesh, n)) begin
         for (int k = 0; k < 3; k++) begin
            n.last = (k == 2);
            pending_normals.push_back(n);
            typed_flags.push_back(known);
            want.last = (k == 2);
            typed_normals.push_back(want);
         end
      end
   endtask

   // result side: random stalls, field by field compare
   always @(posedge clock) begin
      normal_type got, exp_n, tn;
      logic tk;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser, rsp_tlast};
            if (pending_normals.size() == 0) begin
               $error("result transfer with nothing expected");
               failures++;
            end else begin
               exp_n = pending_normals.pop_front();
               tk = typed_flags.pop_front();
               tn = typed_normals.pop_front();
               if (tk && tn != exp_n) begin
                  $error("typed-in row disagrees with predictor: %h vs %h", tn, exp_n);
                  failures++;
               end
               if (got.nx != exp_n.nx) begin
                  $error("normal_x expected %h actual %h", exp_n.nx, got.nx); failures++;
               end
               if (got.ny != exp_n.ny) begin
                  $error("normal_y expected %h actual %h", exp_n.ny, got.ny); failures++;
               end
               if (got.nz != exp_n.nz) begin
                  $error("normal_z expected %h actual %h", exp_n.nz, got.nz); failures++;
               end
               if (got.degen != exp_n.degen) begin
                  $error("degenerate expected %b actual %b", exp_n.degen, got.degen);
                  failures++;
               end
               if (got.last != exp_n.last) begin
                  $error("last_copy expected %b actual %b", exp_n.last, got.last);
                  failures++;
               end
            end
         end
         // mostly ready, short random gaps, now and then a long stall
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if ($urandom_range(29) == 0) begin
            stall_left <= $urandom_range(40, 10);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(3) != 0);
         end
      end
   end

   // watchdog on cycles with no transfer on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(15)) - 16'd8;
         default: return 16'($urandom);
      endcase
   endfunction

   vertex_row_type directed [$];
   normal_type none_n = '0;

   function automatic vertex_row_type row(logic [15:0] x, y, z, logic mesh,
                                           logic known, normal_type want);
      vertex_row_type r;
      r.x = x; r.y = y; r.z = z; r.mesh = mesh; r.known = known; r.want = want;
      return r;
   endfunction

   initial begin
      normal_type unit_z, degen_n, neg_z;
      unit_z  = '{nx:16'd0, ny:16'd0, nz:16'h4000, degen:1'b0, last:1'b0};
      neg_z   = '{nx:16'd0, ny:16'd0, nz:16'hc000, degen:1'b0, last:1'b0};
      degen_n = '{nx:16'd0, ny:16'd0, nz:16'd0, degen:1'b1, last:1'b0};
      // right triangle in xy plane: normal +z
      directed.push_back(row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'hff00, 16'h0000, 16'h0000, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h0000, 16'h0100, 16'h0000, 1'b0, 1'b1, unit_z));
      // reversed winding: normal -z
      directed.push_back(row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h0100, 16'h0000, 16'h0000, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h0000, 16'h0100, 16'h0000, 1'b0, 1'b1, neg_z));
      // degenerate: all corners equal
      directed.push_back(row(16'h1234, 16'h1234, 16'h1234, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h1234, 16'h1234, 16'h1234, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h1234, 16'h1234, 16'h1234, 1'b0, 1'b1, degen_n));
      // mesh restart mid triangle, then extremes that need reduction
      directed.push_back(row(16'h8000, 16'h7fff, 16'h8000, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h7fff, 16'h8000, 16'h7fff, 1'b1, 1'b0, none_n));
      directed.push_back(row(16'h8000, 16'h8000, 16'h7fff, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h7fff, 16'h7fff, 16'h8000, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h8000, 16'h7fff, 16'h7fff, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'h7fff, 16'h8000, 16'h8000, 1'b1, 1'b0, none_n));
      directed.push_back(row(16'h0001, 16'hffff, 16'h0000, 1'b0, 1'b0, none_n));
      directed.push_back(row(16'hffff, 16'h0001, 16'h7fff, 1'b0, 1'b0, none_n));
      // restart on a first corner, then an incomplete pair
      directed.push_back(row(16'h0003, 16'h0005, 16'h0007, 1'b1, 1'b0, none_n));
      directed.push_back(row(16'hfffd, 16'h0002, 16'h0001, 1'b0, 1'b0, none_n));

      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      corner_a = '{0, 0, 0};
      corner_b = '{0, 0, 0};
      phase = 2'd0;
      @(posedge clock);

      foreach (directed[i])
         send_vertex(directed[i].x, directed[i].y, directed[i].z, directed[i].mesh,
                     directed[i].known, directed[i].want);

      // random part: mostly clean triangles, some restarts and noise
      for (int i = 0; i < RANDOM_ITEMS; i++)
         send_vertex(rand_coord(), rand_coord(), rand_coord(),
                     ($urandom_range(11) == 0), 1'b0, none_n);
      req_tvalid <= 1'b0;

      while (pending_normals.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
